// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with reset disable.
`define OKVT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define OKVT_NEVER(lbl, clk, rstn, cond, msg) \
  `OKVT_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

// ===== src/okvt_pkg.sv =====
// Package for the ordered key/value table: codes, widths and control structs.
`default_nettype none
package okvt_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned VAL_W     = 64;
  localparam int unsigned CNT_OUT_W = 5;
  localparam int unsigned IN_DATA_W  = KEY_W + VAL_W;            // 128, byte aligned
  localparam int unsigned OUT_DATA_W = 72;                       // 64 + 5 padded to bytes

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_SET    = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_EXEC
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch the incoming beat
    logic match;     // register the key compare vector
    logic exec;      // apply the command and load the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // output register empty or being drained this cycle
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/okvt_ctrl.sv =====
// Controller state machine: accept, match, execute sequencing.
`default_nettype none
module okvt_ctrl (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       s_valid_i,
  output logic                      s_ready_o,
  output okvt_pkg::ctrl_cmd_t       cmd_o,
  input  wire okvt_pkg::dp_stat_t   stat_i
);
  import okvt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    s_ready_o = 1'b0;
    cmd_o     = '0;
    case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = S_EXEC;
      end
      S_EXEC: begin
        // the next beat is taken in the same cycle the current one retires
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          s_ready_o  = 1'b1;
          if (s_valid_i) begin
            cmd_o.capture = 1'b1;
            state_d       = S_MATCH;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/okvt_dp.sv =====
// Datapath: entry registers, parallel key match, compaction and output register.
`default_nettype none
module okvt_dp #(
  parameter int unsigned DEPTH = okvt_pkg::DEPTH_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire okvt_pkg::ctrl_cmd_t        cmd_i,
  output okvt_pkg::dp_stat_t              stat_o,
  input  wire [okvt_pkg::CMD_W-1:0]       in_cmd_i,
  input  wire [okvt_pkg::KEY_W-1:0]       in_key_i,
  input  wire [okvt_pkg::VAL_W-1:0]       in_val_i,
  input  wire                             m_ready_i,
  output logic                            m_valid_o,
  output logic [okvt_pkg::STAT_W-1:0]     m_status_o,
  output logic [okvt_pkg::VAL_W-1:0]      m_rd_o,
  output logic [okvt_pkg::CNT_OUT_W-1:0]  m_cnt_o
);
  import okvt_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_e             cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;

  logic [KEY_W-1:0] keys_q [DEPTH];
  logic [VAL_W-1:0] vals_q [DEPTH];
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DEPTH-1:0] hit_q, hit_d;

  logic [DEPTH-1:0] first;
  logic [DEPTH-1:0] at_or_above;
  logic             found;
  logic             full;
  logic [VAL_W-1:0] sel_val;
  status_e          status;
  logic [VAL_W-1:0] rd_val;
  logic [CW+CNT_OUT_W-1:0] cnt_ext;

  logic                 m_valid_q;
  logic [STAT_W-1:0]    m_status_q;
  logic [VAL_W-1:0]     m_rd_q;
  logic [CNT_OUT_W-1:0] m_cnt_q;

  assign stat_o.out_free = !m_valid_q || m_ready_i;

  // input beat capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= cmd_e'(in_cmd_i);
      key_q <= in_key_i;
      val_q <= in_val_i;
    end
  end

  // one compare per entry, limited to the filled positions
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit_d[i] = (keys_q[i] == key_q) && (CW'(i) < cnt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.match) begin
      hit_q <= hit_d;
    end
  end

  // lowest hit wins; entries from it upward shift down on remove
  assign first       = hit_q & (~hit_q + DEPTH'(1));
  assign found       = |hit_q;
  assign at_or_above = ~(first - DEPTH'(1)) & {DEPTH{found}};
  assign full        = (cnt_q == CW'(DEPTH));

  always_comb begin
    sel_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_val = sel_val | (vals_q[i] & {VAL_W{first[i]}});
    end
  end

  always_comb begin
    status = ST_DONE;
    rd_val = '0;
    cnt_d  = cnt_q;
    case (cmd_q)
      CMD_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (!found) begin
          status = ST_NOT_FOUND;
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      CMD_GET: begin
        if (!found) begin
          status = ST_NOT_FOUND;
        end else begin
          rd_val = sel_val;
        end
      end
      CMD_SET: begin
        if (!found) status = ST_NOT_FOUND;
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  assign cnt_ext = {{CNT_OUT_W{1'b0}}, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.exec) begin
      cnt_q <= cnt_d;
    end
  end

  // entry storage, no reset: positions at or beyond the count are never read
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      case (cmd_q)
        CMD_APPEND: begin
          if (!full) begin
            for (int i = 0; i < DEPTH; i++) begin
              if (CW'(i) == cnt_q) begin
                keys_q[i] <= key_q;
                vals_q[i] <= val_q;
              end
            end
          end
        end
        CMD_REMOVE: begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (at_or_above[i]) begin
              keys_q[i] <= keys_q[i+1];
              vals_q[i] <= vals_q[i+1];
            end
          end
        end
        CMD_SET: begin
          for (int i = 0; i < DEPTH; i++) begin
            if (first[i]) vals_q[i] <= val_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      m_status_q <= status;
      m_rd_q     <= rd_val;
      m_cnt_q    <= cnt_ext[CNT_OUT_W-1:0];
    end
  end

  assign m_valid_o  = m_valid_q;
  assign m_status_o = m_status_q;
  assign m_rd_o     = m_rd_q;
  assign m_cnt_o    = m_cnt_q;

endmodule
`default_nettype wire

// ===== src/ordered_key_value_table.sv =====
// Ordered key/value table: first-match get/set/remove, append at the tail.
// A beat is captured when accepted, matched against the entries, then executed into the output register.
// No new beat is accepted during the match step; results must drain for execute to proceed.
// The execute cycle also accepts the next beat; a stalled output holds the execute step.
// Reset empties the table (count to zero) and clears the handshake state;
// entry contents are not cleared and are never read before being written.
`default_nettype none
module ordered_key_value_table #(
  parameter int unsigned DEPTH = okvt_pkg::DEPTH_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire [okvt_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // [63:0] key, [127:64] value
  input  wire [okvt_pkg::CMD_W-1:0]         s_axis_tuser,   // [1:0] command
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [okvt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // [63:0] read_value,
                                                            // [68:64] entry_count, rest zero
  output logic [okvt_pkg::STAT_W-1:0]       m_axis_tuser    // [1:0] status
);
  import okvt_pkg::*;

  ctrl_cmd_t            ctrl_cmd;
  dp_stat_t             dp_stat;
  logic [VAL_W-1:0]     rd_val;
  logic [CNT_OUT_W-1:0] cnt_val;

  okvt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .cmd_o     (ctrl_cmd),
    .stat_i    (dp_stat)
  );

  okvt_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (ctrl_cmd),
    .stat_o     (dp_stat),
    .in_cmd_i   (s_axis_tuser),
    .in_key_i   (s_axis_tdata[KEY_W-1:0]),
    .in_val_i   (s_axis_tdata[KEY_W+VAL_W-1:KEY_W]),
    .m_ready_i  (m_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .m_status_o (m_axis_tuser),
    .m_rd_o     (rd_val),
    .m_cnt_o    (cnt_val)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - VAL_W - CNT_OUT_W){1'b0}}, cnt_val, rd_val};

endmodule
`default_nettype wire

// ===== src/okvt_checker.sv =====
// Port-level checker for the ordered key/value table, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module okvt_checker #(
  parameter int unsigned DEPTH = okvt_pkg::DEPTH_DEF
) (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               s_axis_tvalid,
  input wire                               s_axis_tready,
  input wire [okvt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input wire [okvt_pkg::CMD_W-1:0]         s_axis_tuser,
  input wire                               m_axis_tvalid,
  input wire                               m_axis_tready,
  input wire [okvt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input wire [okvt_pkg::STAT_W-1:0]        m_axis_tuser
);
  import okvt_pkg::*;

  // a stalled result beat holds its payload
  `OKVT_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result beat changed while stalled")

  // each accepted beat passes through the match state before the next can enter
  `OKVT_ASSERT(a_no_back_to_back, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input accepted in consecutive cycles")

  // only a successful operation can return a nonzero value
  `OKVT_ASSERT(a_rd_zero_on_fail, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != ST_DONE) |-> m_axis_tdata[VAL_W-1:0] == '0, "nonzero read value on failed operation")

  // entry count never exceeds the table size
  `OKVT_NEVER(a_count_range, clk_i, rst_ni, m_axis_tvalid && (DEPTH < 32) && (32'(m_axis_tdata[VAL_W+CNT_OUT_W-1:VAL_W]) > DEPTH), "entry count beyond table depth")

endmodule

bind ordered_key_value_table okvt_checker #(.DEPTH(DEPTH)) u_okvt_checker (.*);
`default_nettype wire
